FILE: hdl/fvn_pkg.sv
// ============================================================================
// fvn_pkg: shared types and constants for the fractal value noise block
// Field widths, hash constants, smoothing kernel taps and the status struct
// passed between the sequencing core, the divider and the top level.
// ============================================================================
package fvn_pkg;

	// Interface widths
	localparam int OCT_W       = 4;
	localparam int COORD_W     = 32;
	localparam int NOISE_W     = 17;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 24;

	// Octave count after reset and default octave limit
	localparam logic [OCT_W-1:0] OCT_RESET   = 4'd4;
	localparam int               MAX_OCTAVES_DEF = 8;

	// Datapath widths
	localparam int FRAC_W    = 16;          // fraction bits of the point
	localparam int FX_W      = 17;          // signed fraction
	localparam int LAT_W     = 32;          // lattice value, 1 .. 2^31
	localparam int ACC_W     = 36;          // smoothing kernel sum
	localparam int SMOOTH_SH = 15;          // kernel sum to Q.20
	localparam int S_W       = 21;          // smoothed value, Q.20
	localparam int AB_W      = 40;          // x interpolation result
	localparam int D_W       = 41;          // difference of the two rows
	localparam int V_W       = 58;          // bilinear result
	localparam int V_SH      = 20;          // bilinear result to 2^-32 units
	localparam int OCT_VAL_W = 38;          // one octave, 2^-32 units
	localparam int MUL_W     = 33;          // signed multiplier operand
	localparam int PROD_W    = 2 * MUL_W;

	// Hash constants
	localparam logic [31:0] LAT_STEP_X = 32'd1000;
	localparam logic [31:0] LAT_STEP_Y = 32'd57000;
	localparam int          HASH_SHL   = 13;
	localparam logic [31:0] HASH_M1    = 32'd15731;
	localparam logic [31:0] HASH_A1    = 32'd789221;
	localparam logic [31:0] HASH_A2    = 32'd1376312589;
	localparam logic [31:0] HASH_ONE   = 32'h8000_0000;

	// Sequencing
	localparam int SM_TAPS   = 9;           // kernel taps per corner
	localparam int GRID_PTS  = 16;          // 4 x 4 lattice window
	localparam int DIV_STEPS = 18;          // quotient bits, one spare for overflow
	localparam int Q_W       = DIV_STEPS;
	localparam int DIV_PRE   = DIV_STEPS - 1;
	localparam logic [NOISE_W-1:0] NOISE_ONE = 17'd65536;

	// Status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} fvn_stat_t;

	// One smoothing kernel tap: window offset and weight as a shift
	typedef struct packed {
		logic [1:0] da;
		logic [1:0] db;
		logic [1:0] sh;
	} fvn_tap_t;

	// Kernel taps: four corners (1/16), four sides (1/8), centre (1/4)
	function automatic fvn_tap_t fvn_tap(input logic [3:0] tp);
		fvn_tap_t r;
		r = '0;
		case (tp)
			4'd0: r = '{da: 2'd0, db: 2'd0, sh: 2'd0};
			4'd1: r = '{da: 2'd2, db: 2'd0, sh: 2'd0};
			4'd2: r = '{da: 2'd0, db: 2'd2, sh: 2'd0};
			4'd3: r = '{da: 2'd2, db: 2'd2, sh: 2'd0};
			4'd4: r = '{da: 2'd0, db: 2'd1, sh: 2'd1};
			4'd5: r = '{da: 2'd2, db: 2'd1, sh: 2'd1};
			4'd6: r = '{da: 2'd1, db: 2'd0, sh: 2'd1};
			4'd7: r = '{da: 2'd1, db: 2'd2, sh: 2'd1};
			4'd8: r = '{da: 2'd1, db: 2'd1, sh: 2'd2};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Hash seed offset of window point (a, b) from the window origin
	function automatic logic [31:0] fvn_lat_off(input logic [3:0] pt);
		logic [31:0] ox;
		logic [31:0] oy;
		ox = 32'(pt[1:0]) * LAT_STEP_X;
		oy = 32'(pt[3:2]) * LAT_STEP_Y;
		return ox + oy;
	endfunction

endpackage

FILE: hdl/fvn_core.sv
// ============================================================================
// fvn_core: octave sequencer around one shared multiplier
// Per octave: split the point, hash a 4 x 4 lattice window, smooth the four
// cell corners, interpolate bilinearly and fold the octave into the
// amplitude-weighted total.
// ============================================================================
module fvn_core #(
	parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 start,
	input  logic signed [fvn_pkg::COORD_W-1:0]                   x,
	input  logic signed [fvn_pkg::COORD_W-1:0]                   y,
	input  logic [$clog2(MAX_OCTAVES+1)-1:0]                     n,
	output logic signed [MAX_OCTAVES+fvn_pkg::OCT_VAL_W-1:0]     total,
	output fvn_pkg::fvn_stat_t                                   stat
);
	import fvn_pkg::*;

	localparam int NW  = $clog2(MAX_OCTAVES + 1);
	localparam int PXW = COORD_W + MAX_OCTAVES;
	localparam int TW  = MAX_OCTAVES + OCT_VAL_W;
	localparam int DHW = D_W - FRAC_W;

	typedef enum logic [14:0] {
		C_IDLE = 15'b000000000000001,
		C_SETX = 15'b000000000000010,
		C_SETY = 15'b000000000000100,
		C_HN   = 15'b000000000001000,
		C_HSQ  = 15'b000000000010000,
		C_HMA  = 15'b000000000100000,
		C_HMB  = 15'b000000001000000,
		C_HST  = 15'b000000010000000,
		C_SM   = 15'b000000100000000,
		C_IA   = 15'b000001000000000,
		C_IB   = 15'b000010000000000,
		C_ID   = 15'b000100000000000,
		C_IH   = 15'b001000000000000,
		C_IL   = 15'b010000000000000,
		C_DONE = 15'b100000000000000
	} core_state_t;

	core_state_t              state_q;
	logic signed [PXW-1:0]    px_q;
	logic signed [PXW-1:0]    py_q;
	logic [NW-1:0]            oct_q;
	logic [3:0]               pt_q;
	logic [1:0]               cn_q;
	logic [3:0]               tp_q;
	logic [31:0]              base_q;
	logic [31:0]              n_q;
	logic [31:0]              t_q;
	logic [LAT_W-1:0]         lat_q [GRID_PTS];
	logic [ACC_W-1:0]         acc_q;
	logic [S_W-1:0]           s_q [4];
	logic signed [FX_W-1:0]   fx_q;
	logic signed [FX_W-1:0]   fy_q;
	logic signed [AB_W-1:0]   a_q;
	logic signed [AB_W-1:0]   b_q;
	logic signed [D_W-1:0]    d_q;
	logic signed [V_W-1:0]    v_q;
	logic signed [TW-1:0]     total_q;

	// Point split: integer part truncated toward zero, signed fraction
	logic [FRAC_W-1:0]        fracx, fracy;
	logic                     negx, negy;
	logic [31:0]              ixs, iys, ixm1, iym1;

	assign fracx = px_q[FRAC_W-1:0];
	assign fracy = py_q[FRAC_W-1:0];
	assign negx  = px_q[PXW-1] & (|fracx);
	assign negy  = py_q[PXW-1] & (|fracy);
	assign ixs   = 32'(signed'(px_q[PXW-1:FRAC_W]));
	assign iys   = 32'(signed'(py_q[PXW-1:FRAC_W]));
	assign ixm1  = ixs + (negx ? 32'd0 : 32'hFFFF_FFFF);
	assign iym1  = iys + (negy ? 32'd0 : 32'hFFFF_FFFF);

	// Hash seed of the current window point; the shift-xor mix is applied in C_HN
	logic [31:0] seed;
	assign seed = base_q + fvn_lat_off(pt_q);

	// Smoothing tap read
	fvn_tap_t         tap;
	logic [3:0]       addr;
	logic [LAT_W-1:0] lat_rd;
	logic [ACC_W-1:0] acc_nx;

	assign tap    = fvn_tap(tp_q);
	assign addr   = {2'(tap.db + {1'b0, cn_q[1]}), 2'(tap.da + {1'b0, cn_q[0]})};
	assign lat_rd = lat_q[addr];
	assign acc_nx = acc_q + (ACC_W'(lat_rd) << tap.sh);

	// Interpolation operands
	logic [S_W-1:0]          s_lo, s_hi;
	logic signed [S_W:0]     sd;
	logic signed [AB_W-1:0]  s_base;
	logic signed [DHW-1:0]   dh;
	logic signed [OCT_VAL_W-1:0] oct_v;
	logic signed [TW-1:0]    total_nx;

	assign s_lo   = (state_q == C_IA) ? s_q[0] : s_q[2];
	assign s_hi   = (state_q == C_IA) ? s_q[1] : s_q[3];
	assign sd     = $signed({1'b0, s_hi}) - $signed({1'b0, s_lo});
	assign s_base = $signed({3'b000, s_lo, 16'h0000});
	assign dh     = d_q[D_W-1:FRAC_W];
	assign oct_v  = OCT_VAL_W'(v_q >>> V_SH);

	// Weight by halving amplitude: Horner form over octaves
	assign total_nx = (total_q <<< 1) + TW'(oct_v);

	// Shared multiplier
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			C_SETX: begin
				mul_a = $signed({1'b0, ixm1});
				mul_b = $signed({1'b0, LAT_STEP_X});
			end
			C_SETY: begin
				mul_a = $signed({1'b0, iym1});
				mul_b = $signed({1'b0, LAT_STEP_Y});
			end
			C_HSQ: begin
				mul_a = $signed({1'b0, n_q});
				mul_b = $signed({1'b0, n_q});
			end
			C_HMA: begin
				mul_a = $signed({1'b0, t_q});
				mul_b = $signed({1'b0, HASH_M1});
			end
			C_HMB: begin
				mul_a = $signed({1'b0, n_q});
				mul_b = $signed({1'b0, t_q});
			end
			C_IA, C_IB: begin
				mul_a = MUL_W'(sd);
				mul_b = MUL_W'(fx_q);
			end
			C_IH: begin
				mul_a = MUL_W'(dh);
				mul_b = MUL_W'(fy_q);
			end
			C_IL: begin
				mul_a = $signed({{(MUL_W-FRAC_W){1'b0}}, d_q[FRAC_W-1:0]});
				mul_b = MUL_W'(fy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			oct_q   <= '0;
			pt_q    <= '0;
			cn_q    <= '0;
			tp_q    <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						oct_q   <= '0;
						state_q <= C_SETX;
					end
				end
				C_SETX: state_q <= C_SETY;
				C_SETY: begin
					pt_q    <= '0;
					state_q <= C_HN;
				end
				C_HN:  state_q <= C_HSQ;
				C_HSQ: state_q <= C_HMA;
				C_HMA: state_q <= C_HMB;
				C_HMB: state_q <= C_HST;
				C_HST: begin
					pt_q <= pt_q + 1'b1;
					if (pt_q == 4'(GRID_PTS - 1)) begin
						cn_q    <= '0;
						tp_q    <= '0;
						state_q <= C_SM;
					end else begin
						state_q <= C_HN;
					end
				end
				C_SM: begin
					if (tp_q == 4'(SM_TAPS - 1)) begin
						tp_q <= '0;
						cn_q <= cn_q + 1'b1;
						if (cn_q == 2'd3) begin
							state_q <= C_IA;
						end
					end else begin
						tp_q <= tp_q + 1'b1;
					end
				end
				C_IA: state_q <= C_IB;
				C_IB: state_q <= C_ID;
				C_ID: state_q <= C_IH;
				C_IH: state_q <= C_IL;
				C_IL: begin
					// on to the fold step, which folds in the total and then advances to the next octave or finishes
					state_q <= C_DONE;
				end
				C_DONE: begin
					if (oct_q == NW'(n - 1'b1)) begin
						state_q <= C_IDLE;
					end else begin
						oct_q   <= oct_q + 1'b1;
						state_q <= C_SETX;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					px_q    <= PXW'(x);
					py_q    <= PXW'(y);
					total_q <= '0;
				end
			end
			C_SETX: begin
				base_q <= prod[31:0];
				fx_q   <= $signed({negx, fracx});
				fy_q   <= $signed({negy, fracy});
			end
			C_SETY: base_q <= base_q + prod[31:0];
			C_HN:   n_q    <= seed ^ (seed << HASH_SHL);
			C_HSQ:  t_q    <= prod[31:0];
			C_HMA:  t_q    <= prod[31:0] + HASH_A1;
			C_HMB:  t_q    <= prod[31:0] + HASH_A2;
			C_HST: begin
				lat_q[pt_q] <= HASH_ONE - {1'b0, t_q[30:0]};
				acc_q       <= '0;
			end
			C_SM: begin
				if (tp_q == 4'(SM_TAPS - 1)) begin
					s_q[cn_q] <= S_W'(acc_nx >> SMOOTH_SH);
					acc_q     <= '0;
				end else begin
					acc_q <= acc_nx;
				end
			end
			C_IA: a_q <= s_base + AB_W'(prod);
			C_IB: b_q <= s_base + AB_W'(prod);
			C_ID: begin
				d_q <= D_W'(b_q) - D_W'(a_q);
				v_q <= V_W'(a_q) <<< FRAC_W;
			end
			C_IH: v_q <= v_q + (V_W'(prod) <<< FRAC_W);
			C_IL: v_q <= v_q + V_W'(prod);
			C_DONE: begin
				total_q <= total_nx;
				px_q    <= px_q <<< 1;
				py_q    <= py_q <<< 1;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Hand out the total with the current octave folded in; it is taken on
	// the last fold cycle, while done is high
	assign total = total_nx;
	assign stat  = '{busy: (state_q != C_IDLE),
			done: ((state_q == C_DONE) && (oct_q == NW'(n - 1'b1)))};

endmodule

FILE: hdl/fvn_div.sv
// ============================================================================
// fvn_div: normalizing divider
// Divides the weighted octave total by (2^n - 1) * 2^16 with a restoring
// shift-subtract loop, one quotient bit per cycle, then clamps to 0 .. 1.0.
// ============================================================================
module fvn_div #(
	parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	input  logic signed [MAX_OCTAVES+fvn_pkg::OCT_VAL_W-1:0] total,
	input  logic [$clog2(MAX_OCTAVES+1)-1:0]                 n,
	output logic [fvn_pkg::NOISE_W-1:0]                      quo,
	output fvn_pkg::fvn_stat_t                               stat
);
	import fvn_pkg::*;

	localparam int NW = $clog2(MAX_OCTAVES + 1);
	localparam int TW = MAX_OCTAVES + OCT_VAL_W;
	localparam int RW = TW - 1;
	localparam int CW = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_DONE = 3'b100
	} div_state_t;

	div_state_t        state_q;
	logic [RW-1:0]     rem_q;
	logic [RW-1:0]     dsh_q;
	logic [Q_W-1:0]    q_q;
	logic [CW-1:0]     cnt_q;
	logic              zero_q;

	// Divisor mask: n low ones
	logic [MAX_OCTAVES-1:0] mask;
	always_comb begin
		for (int j = 0; j < MAX_OCTAVES; j++) begin
			mask[j] = (NW'(j) < n);
		end
	end

	logic ge;
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b1;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						// drop non-positive totals straight to zero
						if (total[TW-1] || (total == '0)) begin
							zero_q  <= 1'b1;
							state_q <= D_DONE;
						end else begin
							zero_q  <= 1'b0;
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						state_q <= D_DONE;
					end
				end
				D_DONE:  state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Shift-subtract datapath
	always_ff @(posedge clk) begin
		if ((state_q == D_IDLE) && start) begin
			rem_q <= RW'(total);
			dsh_q <= RW'({mask, {(FRAC_W + DIV_PRE){1'b0}}});
			q_q   <= '0;
		end else if (state_q == D_RUN) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			q_q   <= {q_q[Q_W-2:0], ge};
		end
	end

	// Saturate above 1.0
	always_comb begin
		if (zero_q) begin
			quo = '0;
		end else if (q_q > Q_W'(NOISE_ONE)) begin
			quo = NOISE_ONE;
		end else begin
			quo = q_q[NOISE_W-1:0];
		end
	end

	assign stat = '{busy: (state_q != D_IDLE), done: (state_q == D_DONE)};

endmodule

FILE: hdl/fractal_value_noise.sv
// ============================================================================
// fractal_value_noise: fractal value noise over a Q16.16 point
// Sums octave_count octaves of smoothed, bilinearly interpolated lattice
// noise and returns the normalized result in unsigned Q1.16.
// ============================================================================
// Usage:
//   Slave stream s_*: one beat carries one point, x in tdata[31:0] and
//   y in tdata[63:32], both signed Q16.16. Master stream m_*: one beat per
//   point, noise in tdata[16:0], 0 .. 65536.
//   cfg_we / cfg_wdata write the octave count; 0 acts as 1, values above
//   MAX_OCTAVES act as MAX_OCTAVES. Write it only while the block is idle.
// Sequencing:
//   Each octave is two setup steps, sixteen lattice hashes of five steps
//   each on the one shared multiplier, 36 smoothing taps, five
//   interpolation steps and one fold step. The divider then computes 18
//   quotient bits and takes a done step; a total that is zero or negative
//   goes straight to the done step.
//   s_tready is high only while no point is in work; one point at a time.
// Reset and stall:
//   Reset sets the octave count to 4 and empties the output register.
//   A finished result waits in the output register; a new point is taken
//   meanwhile, and its result waits until the previous beat is taken.
// ============================================================================
module fractal_value_noise #(
	parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fvn_pkg::IN_TDATA_W-1:0]      s_tdata,   // coord_x, coord_y
	// master stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fvn_pkg::OUT_TDATA_W-1:0]     m_tdata,   // noise_value, zero fill
	// octave count register
	input  logic                                cfg_we,
	input  logic [fvn_pkg::OCT_W-1:0]           cfg_wdata
);
	import fvn_pkg::*;

	localparam int NW = $clog2(MAX_OCTAVES + 1);
	localparam int TW = MAX_OCTAVES + OCT_VAL_W;
	localparam int CLW = OCT_W + 1;

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_CORE = 4'b0010,
		T_DIV  = 4'b0100,
		T_FIN  = 4'b1000
	} top_state_t;

	top_state_t          state_q;
	logic [OCT_W-1:0]    cfg_q;
	logic [NW-1:0]       n_q;
	logic                m_tvalid_q;
	logic [NOISE_W-1:0]  noise_q;

	fvn_stat_t           core_stat;
	fvn_stat_t           div_stat;
	logic signed [TW-1:0] total;
	logic [NOISE_W-1:0]  quo;
	logic                accept;
	logic                out_free;

	assign s_tready = (state_q == T_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Octave count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= OCT_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Clamp the octave count into 1 .. MAX_OCTAVES
	logic [CLW-1:0] cfg_ext;
	logic [CLW-1:0] n_clamp;
	assign cfg_ext = {1'b0, cfg_q};

	always_comb begin
		if (cfg_q == '0) begin
			n_clamp = CLW'(1);
		end else if (cfg_ext > CLW'(MAX_OCTAVES)) begin
			n_clamp = CLW'(MAX_OCTAVES);
		end else begin
			n_clamp = cfg_ext;
		end
	end

	// Item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			n_q        <= NW'(1);
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						n_q     <= NW'(n_clamp);
						state_q <= T_CORE;
					end
				end
				T_CORE: begin
					if (core_stat.done) begin
						state_q <= T_DIV;
					end
				end
				T_DIV: begin
					if (div_stat.done) begin
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase

			// Hold the result beat until taken
			if ((state_q == T_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if ((state_q == T_FIN) && out_free) begin
			noise_q <= quo;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(noise_q);

	fvn_core #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.x      (s_tdata[COORD_W-1:0]),
		.y      (s_tdata[2*COORD_W-1:COORD_W]),
		.n      (n_q),
		.total  (total),
		.stat   (core_stat)
	);

	fvn_div #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == T_CORE) && core_stat.done),
		.total  (total),
		.n      (n_q),
		.quo    (quo),
		.stat   (div_stat)
	);

`ifndef SYNTH
	// No point is taken while either unit still works on one
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!core_stat.busy && !div_stat.busy))
		else $error("input ready while a unit is busy");

	// The divider starts on the cycle after the core finishes
	a_core_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		core_stat.done |=> div_stat.busy)
		else $error("divider did not start after core finished");

	// A divider result only arrives while the top waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == T_DIV))
		else $error("divider finished outside the divide phase");
`endif

endmodule
